### sv/cdm_pkg.sv
// Shared constants and controller/datapath interface types for the capture duty-cycle meter.
package cdm_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int TS_W           = 16;
    localparam int TICKS_W        = 16;
    localparam int DUTY_W         = 7;
    localparam int DUTY_MAX       = 100;
    localparam int DUTY_SCALE     = 200;
    localparam int Q_BITS         = 7;
    localparam int IDX_W          = $clog2(Q_BITS);

    typedef struct packed {
        logic             cap_rise;
        logic             cap_fall;
        logic             cap_close;
        logic             mul;
        logic             load;
        logic             pre;
        logic             div_step;
        logic [IDX_W-1:0] div_idx;
        logic             finish;
    } cdm_cmd_t;

endpackage

### sv/cdm_dp.sv
// Datapath: capture registers, wrap-around differences, duty multiply and shift-subtract divider.
module cdm_dp #(
    parameter int TIMER_BITS = cdm_pkg::TIMER_BITS_DEF
) (
    input  logic                        clk,
    input  cdm_pkg::cdm_cmd_t           cmd,
    input  logic [cdm_pkg::TS_W-1:0]    timestamp,
    output logic [cdm_pkg::TICKS_W-1:0] period_ticks,
    output logic [cdm_pkg::TICKS_W-1:0] high_ticks,
    output logic [cdm_pkg::DUTY_W-1:0]  duty_percent,
    output logic                        zero_period
);

    localparam int TW = TIMER_BITS;
    localparam int PW = TW + 8;
    localparam int W  = TW + 9;

    logic [TW+cdm_pkg::TS_W-1:0]    ts_ext;
    logic [TW-1:0]                  ts;
    logic [TW-1:0]                  first_reg;
    logic [TW-1:0]                  fall_reg;
    logic [TW-1:0]                  period_reg;
    logic [TW-1:0]                  high_reg;
    logic [PW-1:0]                  prod_reg;
    logic [W-1:0]                   den_reg;
    logic [W-1:0]                   rem_reg;
    logic [W-1:0]                   trial;
    logic [cdm_pkg::Q_BITS-1:0]     q_reg;
    logic                           sat_reg;
    logic [TW+cdm_pkg::TICKS_W-1:0] per_ext;
    logic [TW+cdm_pkg::TICKS_W-1:0] high_ext;
    logic [cdm_pkg::DUTY_W-1:0]     duty_next;
    logic                           zero_next;

    assign ts_ext   = {{TW{1'b0}}, timestamp};
    assign ts       = ts_ext[TW-1:0];
    assign trial    = den_reg << cmd.div_idx;
    assign per_ext  = {{cdm_pkg::TICKS_W{1'b0}}, period_reg};
    assign high_ext = {{cdm_pkg::TICKS_W{1'b0}}, high_reg};
    assign zero_next = (period_reg == '0);

    always_comb
    begin
        if (zero_next)
            duty_next = '0;
        else if (sat_reg || (q_reg > cdm_pkg::DUTY_W'(cdm_pkg::DUTY_MAX)))
            duty_next = cdm_pkg::DUTY_W'(cdm_pkg::DUTY_MAX);
        else
            duty_next = q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_rise)
            first_reg <= ts;
        if (cmd.cap_fall)
            fall_reg <= ts;
        if (cmd.cap_close)
        begin
            period_reg <= ts - first_reg;
            high_reg   <= fall_reg - first_reg;
        end
        if (cmd.mul)
            prod_reg <= PW'(high_reg) * PW'(cdm_pkg::DUTY_SCALE);
        if (cmd.load)
        begin
            rem_reg <= W'(prod_reg) + W'(period_reg);
            den_reg <= W'(period_reg) << 1;
            q_reg   <= '0;
        end
        if (cmd.pre)
            sat_reg <= (rem_reg >= (den_reg << cdm_pkg::Q_BITS));
        if (cmd.div_step && (rem_reg >= trial))
        begin
            rem_reg              <= rem_reg - trial;
            q_reg[cmd.div_idx]   <= 1'b1;
        end
        if (cmd.finish)
        begin
            period_ticks <= per_ext[cdm_pkg::TICKS_W-1:0];
            high_ticks   <= high_ext[cdm_pkg::TICKS_W-1:0];
            duty_percent <= duty_next;
            zero_period  <= zero_next;
        end
    end

endmodule

### sv/cdm_ctrl.sv
// Controller: edge phase tracking, divider sequencing and output word handshake.
module cdm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              edge_rising,
    output logic              out_valid,
    input  logic              out_stall,
    output cdm_pkg::cdm_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_PRE  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [1:0] PH_RISE  = 2'd0;
    localparam logic [1:0] PH_FALL  = 2'd1;
    localparam logic [1:0] PH_CLOSE = 2'd2;

    logic [2:0]                  state_reg, state_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [cdm_pkg::IDX_W-1:0]   cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        in_accept;

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && (phase_reg == PH_CLOSE));
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (phase_reg)
                        PH_FALL:
                        begin
                            if (!edge_rising)
                            begin
                                cmd.cap_fall = 1'b1;
                                phase_next   = PH_CLOSE;
                            end
                        end
                        PH_CLOSE:
                        begin
                            if (edge_rising)
                            begin
                                cmd.cap_close = 1'b1;
                                phase_next    = PH_RISE;
                                state_next    = S_MUL;
                            end
                        end
                        default:
                        begin
                            if (edge_rising)
                            begin
                                cmd.cap_rise = 1'b1;
                                phase_next   = PH_FALL;
                            end
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.load   = 1'b1;
                state_next = S_PRE;
            end
            S_PRE:
            begin
                cmd.pre    = 1'b1;
                cnt_next   = cdm_pkg::IDX_W'(cdm_pkg::Q_BITS - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_idx  = cnt_reg;
                if (cnt_reg == '0)
                    state_next = S_FIN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_FIN:
            begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_RISE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (state_reg == S_IDLE))
        else $error("input word accepted while busy");
    a_close_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cap_close |=> (state_reg == S_MUL))
        else $error("closing edge did not start the computation");
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("output word appeared outside finish");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> !out_valid_reg)
        else $error("pending output word overwritten");
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= cdm_pkg::IDX_W'(cdm_pkg::Q_BITS - 1)))
        else $error("divider step index out of range");
`endif

endmodule

### sv/capture_duty_cycle_meter.sv
// Top level of the capture duty-cycle meter: period, high time and rounded duty percent.
//
//  channel | direction | handshake           | fields
//  in      | input     | in_valid / in_stall   | timestamp, edge_rising
//  out     | output    | out_valid / out_stall | period_ticks, high_ticks, duty_percent,
//          |           |                       | zero_period
//
// Edge words that do not close a period leave the meter idle, ready for the next word.
// After a closing rising edge the result word becomes valid once the multiply, load,
// range check, 7-step shift-subtract divider and finish steps have run.
// Reset clears the phase (waiting for a rising edge) and the output valid.
// While a result word waits under out_stall, rise and fall words are still taken;
// once armed for the closing edge, input stalls until the result word is taken.
module capture_duty_cycle_meter #(
    parameter int TIMER_BITS = cdm_pkg::TIMER_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [cdm_pkg::TS_W-1:0]    timestamp,
    input  logic                        edge_rising,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cdm_pkg::TICKS_W-1:0] period_ticks,
    output logic [cdm_pkg::TICKS_W-1:0] high_ticks,
    output logic [cdm_pkg::DUTY_W-1:0]  duty_percent,
    output logic                        zero_period
);

    cdm_pkg::cdm_cmd_t cmd;

    cdm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .edge_rising (edge_rising),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd)
    );

    cdm_dp #(
        .TIMER_BITS (TIMER_BITS)
    ) u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .timestamp    (timestamp),
        .period_ticks (period_ticks),
        .high_ticks   (high_ticks),
        .duty_percent (duty_percent),
        .zero_period  (zero_period)
    );

endmodule
